// File: rtl/tdr_pkg.sv
// shared types and constants of the touchpad raw-xy report decoder
// no dependencies; used by every module of the block by scoped names
`timescale 1ns / 1ps
`default_nettype none

package tdr_pkg;

  // report acceptance
  localparam logic [7:0] RawTouchId   = 8'h02;
  localparam logic [6:0] MinReportLen = 7'd21;
  localparam logic [7:0] SyncMaxCnt   = 8'd2;

  // configuration register indexes
  localparam logic [7:0] CfgEnable      = 8'd0;
  localparam logic [7:0] CfgYSize       = 8'd1;
  localparam logic [7:0] CfgFlipY       = 8'd2;
  localparam logic [7:0] CfgMaxContacts = 8'd3;

  // decoded report queue
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // pending result bits of one report, in emit order
  localparam int unsigned NumRes   = 4;
  localparam int unsigned ResSlot0 = 0;
  localparam int unsigned ResSlot1 = 1;
  localparam int unsigned ResBtn   = 2;
  localparam int unsigned ResSync  = 3;

  typedef enum logic [1:0] {
    KindContact = 2'd0,
    KindButton  = 2'd1,
    KindSync    = 2'd2
  } kind_e;

  typedef struct packed {
    logic        enable;
    logic [15:0] y_size;
    logic        flip_y;
    logic [7:0]  max_contacts;
  } cfg_t;

  // one finger slot after decoding
  typedef struct packed {
    logic [7:0]  key;
    logic        active;
    logic [15:0] x;
    logic [15:0] y;
    logic [7:0]  pressure;
  } slot_t;

  // one accepted report, ready for the back end
  typedef struct packed {
    logic [NumRes-1:0] mask;
    slot_t             slot0;
    slot_t             slot1;
    logic              button;
  } job_t;

  // one result transaction
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  finger_key;
    logic        active;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [7:0]  pressure;
    logic        last;
  } res_t;

endpackage

`default_nettype wire

// File: rtl/tdr_front.sv
// front end: configuration registers, report acceptance and per-slot decode
// depends on tdr_pkg
`timescale 1ns / 1ps
`default_nettype none

module tdr_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_valid_i,
  input  wire logic [7:0]    cfg_index_i,
  input  wire logic [15:0]   cfg_data_i,
  input  wire logic          in_valid_i,
  input  wire logic [7:0]    report_id_i,
  input  wire logic [6:0]    report_length_i,
  input  wire logic [7:0]    frame_flags_i,
  input  wire logic [7:0]    first_key_i,
  input  wire logic [15:0]   first_x_i,
  input  wire logic [15:0]   first_y_i,
  input  wire logic [7:0]    first_contact_i,
  input  wire logic [7:0]    second_key_i,
  input  wire logic [15:0]   second_x_i,
  input  wire logic [15:0]   second_y_i,
  input  wire logic [7:0]    second_contact_i,
  output tdr_pkg::job_t      job_o,
  output logic               job_valid_o
);

  tdr_pkg::cfg_t cfg_q, cfg_d;
  logic          accept_ok;
  logic          eof;

  // configuration registers, unknown indexes ignored
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        tdr_pkg::CfgEnable:      cfg_d.enable       = cfg_data_i[0];
        tdr_pkg::CfgYSize:       cfg_d.y_size       = cfg_data_i;
        tdr_pkg::CfgFlipY:       cfg_d.flip_y       = cfg_data_i[0];
        tdr_pkg::CfgMaxContacts: cfg_d.max_contacts = cfg_data_i[7:0];
        default:                 cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // decode one finger slot
  function automatic tdr_pkg::slot_t decode_slot(
    input logic [7:0]  key,
    input logic [15:0] x,
    input logic [15:0] y,
    input logic [7:0]  contact,
    input logic        flip,
    input logic [15:0] y_size
  );
    tdr_pkg::slot_t s;
    logic [7:0]     lo_sq;
    logic [7:0]     hi_sq;
    logic [8:0]     sq_sum;
    begin
      lo_sq  = {4'd0, contact[3:0]} * {4'd0, contact[3:0]};
      hi_sq  = {4'd0, contact[7:4]} * {4'd0, contact[7:4]};
      sq_sum = {1'b0, lo_sq} + {1'b0, hi_sq};
      s.key    = key;
      s.active = (contact != 8'd0);
      if (s.active) begin
        s.x = x;
        if (!flip) begin
          s.y = y;
        end else if (y > y_size) begin
          s.y = 16'd0;
        end else begin
          s.y = y_size - y;
        end
        s.pressure = sq_sum[8:1];
      end else begin
        s.x        = 16'd0;
        s.y        = 16'd0;
        s.pressure = 8'd0;
      end
      decode_slot = s;
    end
  endfunction

  // classify the report and build the job for the back end
  always_comb begin
    accept_ok = cfg_q.enable && (report_id_i == tdr_pkg::RawTouchId) &&
                (report_length_i >= tdr_pkg::MinReportLen);
    eof       = !frame_flags_i[7];

    job_o.slot0  = decode_slot(first_key_i, first_x_i, first_y_i, first_contact_i,
                               cfg_q.flip_y, cfg_q.y_size);
    job_o.slot1  = decode_slot(second_key_i, second_x_i, second_y_i,
                               second_contact_i, cfg_q.flip_y, cfg_q.y_size);
    job_o.button = frame_flags_i[0];

    job_o.mask                    = '0;
    job_o.mask[tdr_pkg::ResSlot0] = (first_key_i != 8'd0);
    job_o.mask[tdr_pkg::ResSlot1] = (second_key_i != 8'd0);
    job_o.mask[tdr_pkg::ResBtn]   = eof;
    job_o.mask[tdr_pkg::ResSync]  = eof || (cfg_q.max_contacts <= tdr_pkg::SyncMaxCnt);

    // a report with nothing to emit never enters the queue
    job_valid_o = in_valid_i && accept_ok && (job_o.mask != '0);
  end

endmodule

`default_nettype wire

// File: rtl/tdr_queue.sv
// short queue of decoded reports between front and back end
// depends on tdr_pkg
`timescale 1ns / 1ps
`default_nettype none

module tdr_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          wr_en_i,
  input  wire tdr_pkg::job_t wr_job_i,
  output logic               full_o,
  input  wire logic          rd_en_i,
  output tdr_pkg::job_t      rd_job_o,
  output logic               empty_o
);

  localparam logic [tdr_pkg::QPtrW-1:0] LastPtr = tdr_pkg::QPtrW'(tdr_pkg::QDepth - 1);
  localparam logic [tdr_pkg::QCntW-1:0] FullCnt = tdr_pkg::QCntW'(tdr_pkg::QDepth);

  tdr_pkg::job_t               entry_q [tdr_pkg::QDepth];
  logic [tdr_pkg::QPtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [tdr_pkg::QCntW-1:0]   count_q, count_d;

  assign full_o   = (count_q == FullCnt);
  assign empty_o  = (count_q == '0);
  assign rd_job_o = entry_q[rd_ptr_q];

  // occupancy
  always_comb begin
    count_d = count_q;
    if (wr_en_i && !rd_en_i) begin
      count_d = count_q + 1'b1;
    end else if (!wr_en_i && rd_en_i) begin
      count_d = count_q - 1'b1;
    end
  end

  // pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (wr_en_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (rd_en_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      entry_q[wr_ptr_q] <= wr_job_i;
    end
  end

`ifndef ASSERT_OFF
  assert property (@(posedge clk_i) disable iff (!rst_ni) wr_en_i |-> !full_o)
    else $error("tdr_queue: write into full queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) rd_en_i |-> !empty_o)
    else $error("tdr_queue: read from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= FullCnt)
    else $error("tdr_queue: count beyond depth");
`endif

endmodule

`default_nettype wire

// File: rtl/tdr_back.sv
// back end: walks the pending results of the oldest report into the output register
// depends on tdr_pkg
`timescale 1ns / 1ps
`default_nettype none

module tdr_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire tdr_pkg::job_t job_i,
  input  wire logic          job_avail_i,
  output logic               job_done_o,
  output tdr_pkg::res_t      res_o,
  output logic               res_valid_o,
  input  wire logic          res_take_i
);

  logic [tdr_pkg::NumRes-1:0] sent_q, sent_d;
  logic [tdr_pkg::NumRes-1:0] pending;
  logic [tdr_pkg::NumRes-1:0] sel;
  logic                       last;
  logic                       load;
  tdr_pkg::res_t              res_q, res_d;
  logic                       res_valid_q, res_valid_d;

  // pick the first pending result of the head report
  always_comb begin
    pending = job_i.mask & ~sent_q;
    sel     = pending & (~pending + 1'b1);
    last    = ((pending & ~sel) == '0);
    load    = job_avail_i && (!res_valid_q || res_take_i);
  end

  // build the result transaction
  always_comb begin
    res_d      = '0;
    res_d.last = last;
    if (sel[tdr_pkg::ResSlot0]) begin
      res_d.kind       = tdr_pkg::KindContact;
      res_d.finger_key = job_i.slot0.key;
      res_d.active     = job_i.slot0.active;
      res_d.pos_x      = job_i.slot0.x;
      res_d.pos_y      = job_i.slot0.y;
      res_d.pressure   = job_i.slot0.pressure;
    end else if (sel[tdr_pkg::ResSlot1]) begin
      res_d.kind       = tdr_pkg::KindContact;
      res_d.finger_key = job_i.slot1.key;
      res_d.active     = job_i.slot1.active;
      res_d.pos_x      = job_i.slot1.x;
      res_d.pos_y      = job_i.slot1.y;
      res_d.pressure   = job_i.slot1.pressure;
    end else if (sel[tdr_pkg::ResBtn]) begin
      res_d.kind   = tdr_pkg::KindButton;
      res_d.active = job_i.button;
    end else begin
      res_d.kind = tdr_pkg::KindSync;
    end
  end

  // sequencing of sent results and output register valid
  always_comb begin
    sent_d      = sent_q;
    res_valid_d = res_valid_q;
    job_done_o  = 1'b0;
    if (res_take_i && res_valid_q) begin
      res_valid_d = 1'b0;
    end
    if (load) begin
      res_valid_d = 1'b1;
      if (last) begin
        sent_d     = '0;
        job_done_o = 1'b1;
      end else begin
        sent_d = sent_q | sel;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sent_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      sent_q      <= sent_d;
      res_valid_q <= res_valid_d;
    end
  end

  // output payload register
  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_d;
    end
  end

  assign res_o       = res_q;
  assign res_valid_o = res_valid_q;

`ifndef ASSERT_OFF
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   job_avail_i |-> (pending != '0))
    else $error("tdr_back: head report has no pending result");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (res_valid_q && (res_q.kind == tdr_pkg::KindSync)) |-> res_q.last)
    else $error("tdr_back: sync result not marked last");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   job_done_o |=> (sent_q == '0))
    else $error("tdr_back: sequence not cleared after last result");
`endif

endmodule

`default_nettype wire

// File: rtl/touchpad_raw_xy_report_decoder.sv
// Touchpad raw-xy report decoder, top level.
// Input channel: queue-like, a report transaction is taken when push is high
// and full is low. Rejected reports (decoder disabled, id not raw touch,
// length under 21 bytes) and reports with nothing to emit are dropped.
// Result channel: queue-like, the oldest result is on the result ports while
// empty is low and leaves when pop is high. Up to four results per report:
// one contact per nonzero finger key, a button result at end of frame, a
// sync result at end of frame or when max_contacts is at most 2; last marks
// the final one. Config channel: cfg_valid_i/cfg_ready_o (always ready),
// cfg_index_i selects the register, other indexes are ignored.
// A pushed report is first written to the report queue, then its results are registered.
// Throughput: one result per cycle while results are popped as they appear,
// through the single output register fed by the back-end sequencer.
// A two-entry report queue lets pushes continue while results stall;
// when pop stays low the queue fills and full rises.
// Reset clears the configuration registers (decoder disabled), the queue
// and the output register valid flag.
// depends on tdr_pkg, tdr_front, tdr_queue, tdr_back
`timescale 1ns / 1ps
`default_nettype none

module touchpad_raw_xy_report_decoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [7:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  report_id_i,
  input  wire logic [6:0]  report_length_i,
  input  wire logic [7:0]  frame_flags_i,
  input  wire logic [7:0]  first_key_i,
  input  wire logic [15:0] first_x_i,
  input  wire logic [15:0] first_y_i,
  input  wire logic [7:0]  first_contact_i,
  input  wire logic [7:0]  second_key_i,
  input  wire logic [15:0] second_x_i,
  input  wire logic [15:0] second_y_i,
  input  wire logic [7:0]  second_contact_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [1:0]       kind_o,
  output logic [7:0]       finger_key_o,
  output logic             active_o,
  output logic [15:0]      pos_x_o,
  output logic [15:0]      pos_y_o,
  output logic [7:0]       pressure_o,
  output logic             last_o
);

  tdr_pkg::job_t front_job;
  logic          front_valid;
  logic          q_full;
  logic          q_empty;
  tdr_pkg::job_t head_job;
  logic          head_done;
  tdr_pkg::res_t res;
  logic          res_valid;
  logic          in_take;

  assign cfg_ready_o = 1'b1;
  assign full        = q_full;
  assign in_take     = push && !q_full;

  // accept and classify
  tdr_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_take),
    .report_id_i      (report_id_i),
    .report_length_i  (report_length_i),
    .frame_flags_i    (frame_flags_i),
    .first_key_i      (first_key_i),
    .first_x_i        (first_x_i),
    .first_y_i        (first_y_i),
    .first_contact_i  (first_contact_i),
    .second_key_i     (second_key_i),
    .second_x_i       (second_x_i),
    .second_y_i       (second_y_i),
    .second_contact_i (second_contact_i),
    .job_o            (front_job),
    .job_valid_o      (front_valid)
  );

  // decoupling queue
  tdr_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (front_valid),
    .wr_job_i (front_job),
    .full_o   (q_full),
    .rd_en_i  (head_done),
    .rd_job_o (head_job),
    .empty_o  (q_empty)
  );

  // result sequencing
  tdr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (head_job),
    .job_avail_i (!q_empty),
    .job_done_o  (head_done),
    .res_o       (res),
    .res_valid_o (res_valid),
    .res_take_i  (pop)
  );

  // result ports
  assign empty        = !res_valid;
  assign kind_o       = res.kind;
  assign finger_key_o = res.finger_key;
  assign active_o     = res.active;
  assign pos_x_o      = res.pos_x;
  assign pos_y_o      = res.pos_y;
  assign pressure_o   = res.pressure;
  assign last_o       = res.last;

endmodule

`default_nettype wire
